// File: sv/hrsp_pkg.sv
// ----------------------------------------------------------------------------
// hrsp_pkg
// Shared types, character codes and the hex digit decode for the HEX record
// stream parser.
// ----------------------------------------------------------------------------
package hrsp_pkg;

   // character that opens a record
   localparam logic [7:0]  CHAR_COLON      = 8'h3A;

   // character position limits
   localparam logic [9:0]  POS_MAX         = 10'd1023;
   localparam logic [9:0]  POS_COUNT_HI    = 10'd1;
   localparam logic [9:0]  POS_COUNT_LO    = 10'd2;
   localparam logic [9:0]  POS_OFFSET_HI   = 10'd3;
   localparam logic [9:0]  POS_OFFSET_LO   = 10'd6;
   localparam logic [9:0]  POS_KIND        = 10'd8;
   localparam logic [9:0]  POS_DATA_START  = 10'd9;

   // record type low digits that are handled
   localparam logic [3:0]  KIND_DATA       = 4'd0;
   localparam logic [3:0]  KIND_UPPER_ADDR = 4'd4;

   // last digit index of the upper address field
   localparam logic [9:0]  UPPER_LAST_DIGIT = 10'd3;

   // reset value of the default upper address register
   localparam logic [15:0] DEFAULT_UPPER   = 16'h0800;

   // one result item
   typedef struct packed {
      logic [31:0] byte_address;
      logic [7:0]  data_byte;
      logic        last_in_record;
   } rsp_type;

   // result of the decode stage toward the result register
   typedef struct packed {
      logic    valid;
      rsp_type item;
   } result_type;

   // decode one ASCII hex digit, anything else is zero
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      begin
         v = 8'd0;
         if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
         end else if (c inside {[8'h41:8'h46]}) begin
            v = c - 8'h41 + 8'd10;
         end else if (c inside {[8'h61:8'h66]}) begin
            v = c - 8'h61 + 8'd10;
         end
         return v[3:0];
      end
   endfunction

endpackage

// File: sv/hrsp_if.sv
// ----------------------------------------------------------------------------
// hrsp_if
// Valid/ready channels of the HEX record stream parser: characters in,
// data bytes out, and the configuration write channel.
// ----------------------------------------------------------------------------
interface hrsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface hrsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] byte_address;
   logic [7:0]  data_byte;
   logic        last_in_record;

   modport source (output valid, output byte_address, output data_byte,
                   output last_in_record, input ready);
   modport sink   (input valid, input byte_address, input data_byte,
                   input last_in_record, output ready);
endinterface

interface hrsp_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: sv/hrsp_in_stage.sv
// ----------------------------------------------------------------------------
// hrsp_in_stage
// Input register: holds one character until the decode stage takes it.
// ----------------------------------------------------------------------------
module hrsp_in_stage
   import hrsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char,
   input  logic       take,
   output logic       in_valid,
   output logic [7:0] in_char
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] char_ff;

   // accept when empty or when the held item leaves this cycle
   assign req_ready = !valid_ff || take;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // load a new character on accept
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         char_ff <= req_char;
      end
   end

   assign in_valid = valid_ff;
   assign in_char  = char_ff;

endmodule

// File: sv/hrsp_decoder.sv
// ----------------------------------------------------------------------------
// hrsp_decoder
// Record state and per-character decode: tracks position, byte count, type
// digit, load offset and upper address, and forms one data byte result.
// ----------------------------------------------------------------------------
module hrsp_decoder
   import hrsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic [7:0]  in_char,
   input  logic        cfg_write,
   input  logic [15:0] cfg_data,
   output result_type  result
);

   logic [15:0] default_upper_ff;
   logic [9:0]  pos_ff, pos_in;
   logic [7:0]  count_ff, count_in;
   logic [3:0]  kind_ff, kind_in;
   logic [15:0] offset_ff, offset_in;
   logic [15:0] upper_ff, upper_in;
   logic [3:0]  nibble_ff, nibble_in;

   logic [9:0]  pos_next;
   logic [3:0]  digit;
   logic [9:0]  digit_idx;
   logic [8:0]  byte_idx;
   logic        in_data;
   logic        emit;

   // hold the default upper address written over the config channel
   always_ff @(posedge clock) begin
      if (reset) begin
         default_upper_ff <= DEFAULT_UPPER;
      end else if (cfg_write) begin
         default_upper_ff <= cfg_data;
      end
   end

   // saturating position and field indexes
   assign pos_next  = (pos_ff < POS_MAX) ? pos_ff + 10'd1 : pos_ff;
   assign digit     = hex_value(in_char);
   assign digit_idx = pos_next - POS_DATA_START;
   assign byte_idx  = digit_idx[9:1];
   assign in_data   = byte_idx < {1'b0, count_ff};

   // next state of the record fields
   always_comb begin
      pos_in    = pos_ff;
      count_in  = count_ff;
      kind_in   = kind_ff;
      offset_in = offset_ff;
      upper_in  = upper_ff;
      nibble_in = nibble_ff;
      emit      = 1'b0;
      if (in_char == CHAR_COLON) begin
         pos_in = '0;
      end else begin
         pos_in = pos_next;
         if (pos_next == POS_COUNT_HI) begin
            count_in = {4'd0, digit};
         end else if (pos_next == POS_COUNT_LO) begin
            count_in = {count_ff[3:0], digit};
         end else if (pos_next == POS_OFFSET_HI) begin
            offset_in = {12'd0, digit};
         end else if (pos_next > POS_OFFSET_HI && pos_next <= POS_OFFSET_LO) begin
            offset_in = {offset_ff[11:0], digit};
         end else if (pos_next == POS_KIND) begin
            kind_in = digit;
            // data records use the default upper address while it is zero
            if (digit == KIND_DATA && upper_ff == 16'd0) begin
               upper_in = default_upper_ff;
            end
         end else if (pos_next >= POS_DATA_START) begin
            if (kind_ff == KIND_UPPER_ADDR) begin
               if (digit_idx == 10'd0) begin
                  upper_in = {12'd0, digit};
               end else if (digit_idx <= UPPER_LAST_DIGIT) begin
                  upper_in = {upper_ff[11:0], digit};
               end
            end else if (kind_ff == KIND_DATA && in_data) begin
               if (!digit_idx[0]) begin
                  nibble_in = digit;
               end else begin
                  emit = 1'b1;
               end
            end
         end
      end
   end

   // advance the record state on each taken character
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         count_ff  <= '0;
         kind_ff   <= '0;
         offset_ff <= '0;
         upper_ff  <= '0;
         nibble_ff <= '0;
      end else if (take) begin
         pos_ff    <= pos_in;
         count_ff  <= count_in;
         kind_ff   <= kind_in;
         offset_ff <= offset_in;
         upper_ff  <= upper_in;
         nibble_ff <= nibble_in;
      end
   end

   // form the data byte result
   assign result.valid               = emit;
   assign result.item.byte_address   = {upper_ff, offset_ff} + {24'd0, byte_idx[7:0]};
   assign result.item.data_byte      = {nibble_ff, digit};
   assign result.item.last_in_record = (byte_idx[7:0] == count_ff - 8'd1);

endmodule

// File: sv/hrsp_out_stage.sv
// ----------------------------------------------------------------------------
// hrsp_out_stage
// Result register: holds one data byte item until the receiver takes it.
// ----------------------------------------------------------------------------
module hrsp_out_stage
   import hrsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  result_type result,
   output logic       free,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_item
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type item_ff;

   // free when empty or when the held item is taken this cycle
   assign free     = !valid_ff || rsp_ready;
   assign valid_in = take ? result.valid : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // load the payload only when a result is produced
   always_ff @(posedge clock) begin
      if (take && result.valid) begin
         item_ff <= result.item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

// File: sv/hex_record_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// hex_record_stream_parser_unit
// Parses a stream of HEX record characters into addressed data bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one ASCII character per item; ':' opens a record.
//   rsp_chan carries one item per data byte of a record whose low type
//   digit decodes to 0: its 32-bit address, the byte and a final-byte flag.
//   csr_chan writes the default upper address (reset 0x0800), always ready.
//   The user must write it only with no character in flight; unenforced.
// Timing:
//   One character per cycle while rsp_chan is not stalled. A character is
//   held in the input register, is decoded against the record state, and
//   its data byte is loaded into the result register driving rsp_chan.
//   The record state update per character is the loop that sets this rate.
// Stall:
//   While a result waits on rsp_chan, one more character is accepted into
//   the input register; further characters wait until the result is taken.
// Reset:
//   Synchronous, active high; clears both valid flags and the record state.
// ----------------------------------------------------------------------------
module hex_record_stream_parser_unit
   import hrsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   hrsp_req_if.sink   req_chan,
   hrsp_rsp_if.source rsp_chan,
   hrsp_csr_if.sink   csr_chan
);

   logic       in_valid;
   logic [7:0] in_char;
   logic       out_free;
   logic       take;
   result_type result;
   rsp_type    rsp_item;

   // move the held character when the result register can hold its output
   assign take = in_valid && out_free;

   assign csr_chan.ready = 1'b1;

   hrsp_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_char  (req_chan.char_code),
      .take      (take),
      .in_valid  (in_valid),
      .in_char   (in_char)
   );

   hrsp_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .in_char   (in_char),
      .cfg_write (csr_chan.valid),
      .cfg_data  (csr_chan.data),
      .result    (result)
   );

   hrsp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .result    (result),
      .free      (out_free),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_chan.byte_address   = rsp_item.byte_address;
   assign rsp_chan.data_byte      = rsp_item.data_byte;
   assign rsp_chan.last_in_record = rsp_item.last_in_record;

endmodule

// File: test/tb_hex_record_stream_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex_record_stream_parser_unit
// Streams HEX record characters into the parser and checks every data byte it
// emits. A tracker class follows the record state for each accepted character
// and keeps the queue of data bytes the parser owes. Directed records cover
// the header and address corner cases; random records, noise and broken
// records follow under three sender/receiver idle mixes and several default
// upper address settings.
// ----------------------------------------------------------------------------
module tb_hex_record_stream_parser_unit;
   import hrsp_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int REPORT_LINES = 40;

   // Follows the record state and holds the data bytes still owed by the parser.
   class flash_byte_tracker;
      logic [15:0] default_upper;
      logic [9:0]  position;
      logic [7:0]  byte_count;
      logic [3:0]  kind_digit;
      logic [15:0] load_offset;
      logic [15:0] upper_addr;
      logic [3:0]  high_nibble;
      rsp_type     owed_bytes[$];
      int          error_count;

      function new();
         default_upper = DEFAULT_UPPER;
         position      = '0;
         byte_count    = '0;
         kind_digit    = '0;
         load_offset   = '0;
         upper_addr    = '0;
         high_nibble   = '0;
         error_count   = 0;
      endfunction

      // Hex digit value, anything else is zero.
      function logic [3:0] digit_of(input logic [7:0] c);
         if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
         if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h37);
         if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h57);
         return 4'd0;
      endfunction

      // Advance the record state by one accepted character.
      function void note_char(input logic [7:0] c);
         logic [3:0] d;
         logic [9:0] j;
         logic [9:0] k;
         rsp_type    owed;
         if (c == CHAR_COLON) begin
            position = '0;
            return;
         end
         if (position < POS_MAX) position = position + 10'd1;
         d = digit_of(c);
         if (position == POS_COUNT_HI) begin
            byte_count = {4'd0, d};
         end else if (position == POS_COUNT_LO) begin
            byte_count = {byte_count[3:0], d};
         end else if (position == POS_OFFSET_HI) begin
            load_offset = {12'd0, d};
         end else if (position > POS_OFFSET_HI && position <= POS_OFFSET_LO) begin
            load_offset = {load_offset[11:0], d};
         end else if (position == POS_KIND) begin
            kind_digit = d;
            if (d == KIND_DATA && upper_addr == 16'd0) upper_addr = default_upper;
         end else if (position >= POS_DATA_START) begin
            j = position - POS_DATA_START;
            if (kind_digit == KIND_UPPER_ADDR) begin
               if (j == 10'd0) upper_addr = {12'd0, d};
               else if (j <= UPPER_LAST_DIGIT) upper_addr = {upper_addr[11:0], d};
            end else if (kind_digit == KIND_DATA) begin
               k = j >> 1;
               if (k < {2'd0, byte_count}) begin
                  if (!j[0]) begin
                     high_nibble = d;
                  end else begin
                     owed.byte_address   = {upper_addr, 16'd0} + {16'd0, load_offset}
                                           + {22'd0, k};
                     owed.data_byte      = {high_nibble, d};
                     owed.last_in_record = (k + 10'd1 == {2'd0, byte_count});
                     owed_bytes.push_back(owed);
                  end
               end
            end
         end
      endfunction

      task report(input string msg);
         if (error_count < REPORT_LINES) $display("[%0t] MISMATCH: %s", $realtime, msg);
         error_count++;
      endtask

      // Compare one emitted data byte with the oldest owed one.
      task check_result(input rsp_type got);
         rsp_type want;
         if (owed_bytes.size() == 0) begin
            report($sformatf("unexpected byte addr=%h data=%h last=%b",
                             got.byte_address, got.data_byte, got.last_in_record));
            return;
         end
         want = owed_bytes.pop_front();
         if (got.byte_address !== want.byte_address)
            report($sformatf("byte_address got %h want %h", got.byte_address,
                             want.byte_address));
         if (got.data_byte !== want.data_byte)
            report($sformatf("data_byte got %h want %h at %h", got.data_byte,
                             want.data_byte, want.byte_address));
         if (got.last_in_record !== want.last_in_record)
            report($sformatf("last_in_record got %b want %b at %h", got.last_in_record,
                             want.last_in_record, want.byte_address));
      endtask
   endclass

   logic clock;
   logic reset;

   hrsp_req_if req_chan();
   hrsp_rsp_if rsp_chan();
   hrsp_csr_if csr_chan();

   flash_byte_tracker byte_track;
   int          req_idle_pct;
   int          rsp_idle_pct;
   int          chars_sent;
   int          stall_cycles;
   logic [7:0]  line_chars[$];

   hex_record_stream_parser_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #1 clock = ~clock;

   // Randomly stall the result side.
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // Check each result item; inputs settle between edges.
   always @(negedge clock) begin
      rsp_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.byte_address   = rsp_chan.byte_address;
         got.data_byte      = rsp_chan.data_byte;
         got.last_in_record = rsp_chan.last_in_record;
         byte_track.check_result(got);
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(negedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Send one character, idling first at random, and wait for its acceptance.
   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.char_code <= c;
      forever begin
         @(negedge clock);
         if (req_chan.ready) break;
      end
      @(posedge clock);
      byte_track.note_char(c);
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic send_line();
      foreach (line_chars[i]) send_char(line_chars[i]);
      line_chars.delete();
   endtask

   // Hex digit character with random letter case.
   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + {4'd0, v};
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'd0, v} - 8'd10;
   endfunction

   function automatic void push_hex(input logic [15:0] v, input int digits);
      for (int i = digits - 1; i >= 0; i--) line_chars.push_back(hex_char(v[4*i +: 4]));
   endfunction

   // Hold the sender until every owed byte is out and the pipeline is empty.
   task automatic settle_parser();
      req_chan.valid <= 1'b0;
      while (byte_track.owed_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_default_upper(input logic [15:0] v);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= v;
      forever begin
         @(negedge clock);
         if (csr_chan.ready) break;
      end
      @(posedge clock);
      csr_chan.valid <= 1'b0;
      byte_track.default_upper = v;
   endtask

   // Random records, noise and broken records until the character target.
   task automatic send_random_records(input int char_target);
      int          sel;
      int          kind_sel;
      logic [7:0]  count;
      logic [15:0] upper_val;
      int          cut;
      int          stop_at;
      stop_at = chars_sent + char_target;
      while (chars_sent < stop_at) begin
         sel = $urandom_range(0, 99);
         if (sel < 8) begin
            // stray characters between records
            repeat ($urandom_range(1, 6)) line_chars.push_back(8'($urandom_range(0, 255)));
         end else begin
            kind_sel = $urandom_range(0, 99);
            if ($urandom_range(0, 199) == 0) count = 8'hFF;
            else if ($urandom_range(0, 9) == 0) count = 8'($urandom_range(0, 40));
            else count = 8'($urandom_range(0, 8));
            if (kind_sel >= 60 && kind_sel < 80 && $urandom_range(0, 3) != 0) count = 8'd2;
            line_chars.push_back(CHAR_COLON);
            push_hex({8'd0, count}, 2);
            push_hex(16'($urandom), 4);
            line_chars.push_back(hex_char(4'($urandom)));
            if (kind_sel < 60) begin
               line_chars.push_back(8'h30);
               repeat (2 * count) line_chars.push_back(hex_char(4'($urandom)));
            end else if (kind_sel < 80) begin
               line_chars.push_back(8'h34);
               upper_val = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
               push_hex(upper_val, 4);
            end else begin
               // random record types, some with a non-hex type digit
               if ($urandom_range(0, 1)) line_chars.push_back(hex_char(4'($urandom)));
               else line_chars.push_back(8'($urandom_range(0, 255)));
               repeat (2 * count) line_chars.push_back(hex_char(4'($urandom)));
            end
            push_hex(16'($urandom), 2);
            // corrupt or cut some records
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
               line_chars[$urandom_range(1, line_chars.size() - 1)] =
                  8'($urandom_range(0, 255));
            end else if (sel < 16) begin
               cut = $urandom_range(1, line_chars.size() - 1);
               while (line_chars.size() > cut) void'(line_chars.pop_back());
            end
            if ($urandom_range(0, 9) == 0) begin
               line_chars.push_back(8'h0D);
               line_chars.push_back(8'h0A);
            end
         end
         send_line();
      end
   endtask

   initial begin
      byte_track         = new();
      clock              = 1'b0;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.char_code = 8'h00;
      rsp_chan.ready     = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.data      = 16'h0000;
      req_idle_pct       = 33;
      rsp_idle_pct       = 76;
      chars_sent         = 0;
      stall_cycles       = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed records with the reset default upper address.
      send_text("01000000AB54");          // no opening colon after reset
      send_text(":020000040000FA");       // upper address back to zero
      send_text(":02FFFF00ffA5C3");       // default applied, offset carries
      send_text(":00000000FF");           // zero byte count
      send_text(":02000004FFFFFC");       // top upper address
      send_text(":03FFFE0011223344");     // address wraps past the top
      send_text(":0100007Z5a00");         // non-hex type digit means data
      send_text(":0400001000:01002000C3"); // colon abandons a record
      send_text(":/1`@Gg0/Ff");           // boundary characters around the digits
      send_random_records(250);

      // Default upper address at zero, sender mostly idle.
      settle_parser();
      write_default_upper(16'h0000);
      req_idle_pct = 76;
      rsp_idle_pct = 33;
      send_text(":020000040000FA:01123400EE");
      send_random_records(250);

      // Top default, no idling; one long run of stray characters.
      settle_parser();
      write_default_upper(16'hFFFF);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_text(":020000040000FA:0100000077");
      send_text(":00000000");
      repeat (1040) begin
         logic [7:0] c;
         c = 8'($urandom_range(0, 255));
         send_char((c == CHAR_COLON) ? 8'h41 : c);
      end
      send_random_records(150);

      // Random default upper address.
      settle_parser();
      write_default_upper(16'($urandom));
      send_random_records(150);

      settle_parser();
      repeat (8) @(posedge clock);
      if (byte_track.error_count == 0 && byte_track.owed_bytes.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
